// ===== sv/mqfb_pkg.sv =====
// Types and constants shared by the multi-queue FIFO bank.
package mqfb_pkg;

    localparam int DATA_W    = 32;
    localparam int CAP_W     = 5;
    localparam int COUNT_W   = 5;
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = 3;
    localparam int QSEL_W    = 3;
    localparam int APB_AW    = 5;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_PEEK   = 2'd2,
        MODE_COUNT  = 2'd3
    } mode_e;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_EMPTY  = 2'd2,
        STATUS_NOINIT = 2'd3
    } status_e;

    typedef struct packed {
        mode_e                     mode;
        logic [QSEL_W-1:0]         queue_index;
        logic signed [DATA_W-1:0]  data_in;
    } req_beat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  data_out;
        logic [COUNT_W-1:0]        entry_count;
        status_e                   status;
    } rsp_beat_t;

    typedef struct packed {
        logic                  valid;
        logic [REG_IDX_W-1:0]  index;
    } cfg_clear_t;

    typedef struct packed {
        logic                  rd;
        logic [COUNT_W-1:0]    count;
        status_e               status;
    } result_meta_t;

    typedef logic [NUM_REGS-1:0][CAP_W-1:0] cap_array_t;

endpackage

// ===== sv/mqfb_ram.sv =====
// Single-port word store with a registered read port.
module mqfb_ram #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic                               we,
    input  logic [ADDR_W-1:0]                  addr,
    input  logic signed [mqfb_pkg::DATA_W-1:0] wdata,
    output logic signed [mqfb_pkg::DATA_W-1:0] rdata
);

    logic signed [mqfb_pkg::DATA_W-1:0] mem [DEPTH];
    logic signed [mqfb_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/mqfb_regs.sv =====
// APB register file holding the per-queue capacities.
module mqfb_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mqfb_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output mqfb_pkg::cap_array_t          caps,
    output mqfb_pkg::cfg_clear_t          clear
);

    mqfb_pkg::cap_array_t caps_reg;
    logic [mqfb_pkg::REG_IDX_W-1:0] reg_idx;
    logic wr_en;

    assign reg_idx = paddr[mqfb_pkg::APB_AW-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            caps_reg <= '0;
        end
        else if (wr_en)
        begin
            caps_reg[reg_idx] <= pwdata[mqfb_pkg::CAP_W-1:0];
        end
    end

    assign prdata      = {{(32 - mqfb_pkg::CAP_W){1'b0}}, caps_reg[reg_idx]};
    assign caps        = caps_reg;
    assign clear.valid = wr_en;
    assign clear.index = reg_idx;

endmodule

// ===== sv/mqfb_queue_state.sv =====
// Per-queue counts and heads, with the decision and store access for each request.
module mqfb_queue_state #(
    parameter int NUM_QUEUES  = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int ADDR_W      = 7
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  mqfb_pkg::req_beat_t                req,
    input  mqfb_pkg::cap_array_t               caps,
    input  mqfb_pkg::cfg_clear_t               clear,
    output logic                               mem_en,
    output logic                               mem_we,
    output logic [ADDR_W-1:0]                  mem_addr,
    output logic signed [mqfb_pkg::DATA_W-1:0] mem_wdata,
    output mqfb_pkg::result_meta_t             meta
);

    localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int HEAD_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int POS_W  = $clog2(2 * QUEUE_DEPTH);
    localparam logic [mqfb_pkg::COUNT_W-1:0] CAP_LIMIT =
        (QUEUE_DEPTH > 31) ? 5'd31 : mqfb_pkg::COUNT_W'(QUEUE_DEPTH);
    localparam logic [POS_W-1:0]  DEPTH_P = POS_W'(QUEUE_DEPTH);
    localparam logic [ADDR_W-1:0] DEPTH_A = ADDR_W'(QUEUE_DEPTH);

    logic [mqfb_pkg::COUNT_W-1:0] counts_reg [NUM_QUEUES];
    logic [HEAD_W-1:0]            heads_reg  [NUM_QUEUES];

    logic [QIDX_W-1:0]            qi;
    logic                         in_range;
    logic [mqfb_pkg::CAP_W-1:0]   cap_raw;
    logic [mqfb_pkg::CAP_W-1:0]   cap_eff;
    logic [mqfb_pkg::COUNT_W-1:0] cnt;
    logic [HEAD_W-1:0]            head;
    logic [POS_W-1:0]             pos_sum;
    logic [POS_W-1:0]             pos_wrap;
    logic [POS_W-1:0]             head_sum;
    logic [HEAD_W-1:0]            head_inc;
    logic                         do_wr;
    logic                         do_rd;
    logic                         upd_en;
    logic [mqfb_pkg::COUNT_W-1:0] upd_count;
    logic [HEAD_W-1:0]            upd_head;
    logic [QIDX_W-1:0]            clr_q;
    logic                         clr_in_range;

    assign qi       = req.queue_index[QIDX_W-1:0];
    assign in_range = {1'b0, req.queue_index} < (mqfb_pkg::QSEL_W + 1)'(NUM_QUEUES);
    assign cap_raw  = caps[req.queue_index];
    assign cap_eff  = (cap_raw > CAP_LIMIT) ? CAP_LIMIT : cap_raw;
    assign cnt      = counts_reg[qi];
    assign head     = heads_reg[qi];

    assign clr_q        = clear.index[QIDX_W-1:0];
    assign clr_in_range = {1'b0, clear.index} < (mqfb_pkg::REG_IDX_W + 1)'(NUM_QUEUES);

    always_comb
    begin
        pos_sum  = POS_W'(head) +
                   ((req.mode == mqfb_pkg::MODE_INSERT) ? POS_W'(cnt) : '0);
        pos_wrap = (pos_sum >= DEPTH_P) ? (pos_sum - DEPTH_P) : pos_sum;
        head_sum = POS_W'(head) + POS_W'(1);
        head_inc = (head_sum == DEPTH_P) ? '0 : HEAD_W'(head_sum);

        do_wr       = 1'b0;
        do_rd       = 1'b0;
        upd_en      = 1'b0;
        upd_count   = cnt;
        upd_head    = head;
        meta.rd     = 1'b0;
        meta.count  = '0;
        meta.status = mqfb_pkg::STATUS_NOINIT;

        if (in_range && (cap_eff != '0))
        begin
            meta.count  = cnt;
            meta.status = mqfb_pkg::STATUS_OK;
            upd_en      = 1'b1;
            case (req.mode)
                mqfb_pkg::MODE_INSERT:
                begin
                    if (cnt >= cap_eff)
                    begin
                        meta.status = mqfb_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        do_wr      = 1'b1;
                        upd_count  = cnt + 5'd1;
                        meta.count = upd_count;
                    end
                end
                mqfb_pkg::MODE_REMOVE, mqfb_pkg::MODE_PEEK:
                begin
                    if (cnt == '0)
                    begin
                        meta.status = mqfb_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        do_rd   = 1'b1;
                        meta.rd = 1'b1;
                        if (req.mode == mqfb_pkg::MODE_REMOVE)
                        begin
                            upd_count  = cnt - 5'd1;
                            upd_head   = head_inc;
                            meta.count = upd_count;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign mem_en    = accept && (do_wr || do_rd);
    assign mem_we    = do_wr;
    assign mem_addr  = ADDR_W'(qi) * DEPTH_A + ADDR_W'(pos_wrap);
    assign mem_wdata = req.data_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                counts_reg[i] <= '0;
                heads_reg[i]  <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                if (clear.valid && clr_in_range && (clr_q == QIDX_W'(i)))
                begin
                    counts_reg[i] <= '0;
                    heads_reg[i]  <= '0;
                end
                else if (accept && upd_en && (qi == QIDX_W'(i)))
                begin
                    counts_reg[i] <= upd_count;
                    heads_reg[i]  <= upd_head;
                end
            end
        end
    end

    a_count_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_range |=> counts_reg[$past(qi)] <= CAP_LIMIT)
        else $error("queue count exceeds its capacity limit");

    a_remove_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        accept && meta.rd && (req.mode == mqfb_pkg::MODE_REMOVE) && !clear.valid
        |=> counts_reg[$past(qi)] == $past(cnt) - 5'd1)
        else $error("remove did not lower the queue count by one");

endmodule

// ===== sv/multi_queue_fifo_bank.sv =====
// Top level of the multi-queue FIFO bank: store read stage and result register.
//
//  channel | signals                        | beat
//  --------+--------------------------------+---------------------------------
//  request | req_valid, req_ready, req      | mode, queue_index, data_in
//  result  | rsp_valid, rsp_ready, rsp      | data_out, entry_count, status
//  config  | psel, penable, pwrite, paddr.. | queue capacity registers
//
// One request is taken per cycle unless the result side stalls; its result passes the read stage
// register and then the result register, as the single-port word store's read data is registered.
// Reset clears all capacities, counts and heads; the word store needs no clearing.
// A stalled result holds the read stage, and the request side stalls behind it.
module multi_queue_fifo_bank #(
    parameter int NUM_QUEUES  = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  mqfb_pkg::req_beat_t           req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output mqfb_pkg::rsp_beat_t           rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mqfb_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int WORDS  = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

    mqfb_pkg::cap_array_t   caps;
    mqfb_pkg::cfg_clear_t   clear;
    mqfb_pkg::result_meta_t meta;
    mqfb_pkg::result_meta_t s1_meta_reg;
    mqfb_pkg::rsp_beat_t    rsp_reg;
    mqfb_pkg::rsp_beat_t    rsp_next;

    logic                               mem_en;
    logic                               mem_we;
    logic [ADDR_W-1:0]                  mem_addr;
    logic signed [mqfb_pkg::DATA_W-1:0] mem_wdata;
    logic signed [mqfb_pkg::DATA_W-1:0] mem_rdata;

    logic s1_valid_reg;
    logic s1_valid_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic advance;
    logic accept;

    mqfb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .caps    (caps),
        .clear   (clear)
    );

    mqfb_queue_state #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req       (req),
        .caps      (caps),
        .clear     (clear),
        .mem_en    (mem_en),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .meta      (meta)
    );

    mqfb_ram #(
        .DEPTH  (WORDS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign advance   = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || advance;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (advance)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        rsp_next.data_out    = s1_meta_reg.rd ? mem_rdata : '0;
        rsp_next.entry_count = s1_meta_reg.count;
        rsp_next.status      = s1_meta_reg.status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_meta_reg <= meta;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_error_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != mqfb_pkg::STATUS_OK) |-> rsp.data_out == '0)
        else $error("result carries data on an error status");

    a_read_has_stage: assert property (@(posedge clk) disable iff (!rst_n)
        mem_en && !mem_we |=> s1_valid_reg && s1_meta_reg.rd)
        else $error("store read issued without a read stage to take the data");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_meta_reg))
        else $error("stalled read stage lost its beat");

endmodule
